// File: rtl/pbps_pkg.sv
// Package for the priority beep pattern sequencer.
// Holds default parameters, field widths, register indexes, operation codes
// and the sequencing phase type. Depends on nothing.
`timescale 1ns / 1ps

package pbps_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_TONES_DEF   = 2;
    localparam int TIMER_WIDTH_DEF = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Widths of the configuration registers.
    localparam int TICK_W  = 16;
    localparam int COUNT_W = 8;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_REPS  = 3'd4;

    // Register reset values.
    localparam logic [TICK_W-1:0]  PULSE_ON_RST   = 16'd10;
    localparam logic [TICK_W-1:0]  PULSE_OFF_RST  = 16'd0;
    localparam logic [TICK_W-1:0]  TRAIN_GAP_RST  = 16'd0;
    localparam logic [COUNT_W-1:0] PULSES_RST     = 8'd1;
    localparam logic [COUNT_W-1:0] TRAIN_REPS_RST = 8'd1;

    // Operation codes carried by an input transfer.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Phases of the pulse sequencer.
    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_STOP  = 5'b00010,
        PH_NEXT  = 5'b00100,
        PH_CHECK = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

endpackage

// File: rtl/priority_beep_pattern_sequencer_unit.sv
// Top level of the priority beep pattern sequencer.
// Uses pbps_pkg for widths, register indexes, operation codes and the phase type.
`timescale 1ns / 1ps

// The block drives one buzzer from a mask of pending tone requests. Each
// input transfer is either a timer tick (op 0), which advances the phase
// timer and runs one sequencer step, or a request change (op 1), which
// sets and then clears request bits. Tone 0 is a continuous tone; every
// other tone is pulsed with the timing held in the configuration registers.
// The lowest-index pending tone wins and restarts when it takes over.
// Every input transfer yields exactly one result transfer carrying the
// buzzer level, the tone being played (NUM_TONES means none) and the
// pending mask after the item.
// An accepted item is held in the input register and executed from there,
// and the sequencer state itself forms the result register: an item passes
// through the input register and then out_valid_reg on its way to m_valid,
// and one item per cycle is sustained while the receiver keeps up.
// If the receiver stalls, the waiting result holds, the input register
// still takes one more item, and only then does s_ready fall.
// Reset (aresetn low at a clock edge) empties both registers, loads the
// register defaults and leaves no tone pending with the buzzer off.
// Configuration writes take effect on the edge where cfg_wr_en is high.
module priority_beep_pattern_sequencer_unit #(
    parameter int NUM_TONES   = pbps_pkg::NUM_TONES_DEF,
    parameter int TIMER_WIDTH = pbps_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [pbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [NUM_TONES-1:0]             s_tone_set_mask,
    input  logic [NUM_TONES-1:0]             s_tone_clear_mask,
    input  logic                             s_buzzer_available,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_buzzer_on,
    output logic [$clog2(NUM_TONES+1)-1:0]   m_current_tone,
    output logic [NUM_TONES-1:0]             m_pending_tones
);

    import pbps_pkg::*;

    localparam int IDX_W = $clog2(NUM_TONES + 1);
    localparam int CMP_W = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;
    localparam logic [IDX_W-1:0] TONE_NONE = IDX_W'(NUM_TONES);

    // Configuration registers.
    logic [TICK_W-1:0]  pulse_on_reg, pulse_off_reg, train_gap_reg;
    logic [COUNT_W-1:0] pulses_reg, train_reps_reg;

    // Input register.
    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [NUM_TONES-1:0] in_set_reg;
    logic [NUM_TONES-1:0] in_clr_reg;
    logic                 in_avail_reg;

    // Result valid flag; the sequencer state below doubles as result payload.
    logic out_valid_reg, out_valid_next;

    // Sequencer state.
    logic [NUM_TONES-1:0]   request_mask_reg, request_mask_next;
    logic                   was_active_reg, was_active_next;
    phase_t                 phase_reg, phase_next;
    logic [IDX_W-1:0]       last_tone_reg, last_tone_next;
    logic [COUNT_W-1:0]     pulse_count_reg, pulse_count_next;
    logic [COUNT_W-1:0]     train_count_reg, train_count_next;
    logic [TIMER_WIDTH-1:0] phase_timer_reg, phase_timer_next;
    logic                   drive_reg, drive_next;

    // Step decode.
    logic                   exec;
    logic [IDX_W-1:0]       tone_idx;
    logic                   is_pulsed;
    logic [COUNT_W-1:0]     tone_pulses, tone_trains, pulse_inc;
    logic [CMP_W-1:0]       timer_cmp, on_cmp, off_cmp, gap_cmp;
    logic [TIMER_WIDTH-1:0] timer_tick;
    logic [NUM_TONES-1:0]   keep_mask;
    logic                   run_start;

    // The input register moves into the state whenever the result slot is free.
    assign exec    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec;

    assign m_valid         = out_valid_reg;
    assign m_buzzer_on     = drive_reg;
    assign m_current_tone  = last_tone_reg;
    assign m_pending_tones = request_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_on_reg   <= PULSE_ON_RST;
            pulse_off_reg  <= PULSE_OFF_RST;
            train_gap_reg  <= TRAIN_GAP_RST;
            pulses_reg     <= PULSES_RST;
            train_reps_reg <= TRAIN_REPS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PULSE_ON:   pulse_on_reg   <= cfg_wdata[TICK_W-1:0];
                REG_PULSE_OFF:  pulse_off_reg  <= cfg_wdata[TICK_W-1:0];
                REG_TRAIN_GAP:  train_gap_reg  <= cfg_wdata[TICK_W-1:0];
                REG_PULSES:     pulses_reg     <= cfg_wdata[COUNT_W-1:0];
                REG_TRAIN_REPS: train_reps_reg <= cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The payload is captured on every input transfer and needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= s_op;
            in_set_reg   <= s_tone_set_mask;
            in_clr_reg   <= s_tone_clear_mask;
            in_avail_reg <= s_buzzer_available;
        end
    end

    always_comb begin
        if (exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            request_mask_reg <= '0;
            was_active_reg   <= 1'b0;
            phase_reg        <= PH_START;
            last_tone_reg    <= TONE_NONE;
            pulse_count_reg  <= '0;
            train_count_reg  <= '0;
            phase_timer_reg  <= '0;
            drive_reg        <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg    <= out_valid_next;
            request_mask_reg <= request_mask_next;
            was_active_reg   <= was_active_next;
            phase_reg        <= phase_next;
            last_tone_reg    <= last_tone_next;
            pulse_count_reg  <= pulse_count_next;
            train_count_reg  <= train_count_next;
            phase_timer_reg  <= phase_timer_next;
            drive_reg        <= drive_next;
        end
    end

    // Lowest-index pending tone wins; the keep mask retains the bits below it,
    // since a finished tone drops its own bit and every finite tone after it.
    always_comb begin
        tone_idx  = TONE_NONE;
        keep_mask = '0;
        for (int i = NUM_TONES - 1; i >= 0; i--) begin
            if (request_mask_reg[i]) begin
                tone_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < NUM_TONES; i++) begin
            keep_mask[i] = (IDX_W'(i) < tone_idx);
        end
    end

    // Tone 0 has no timing; all pulsed tones share the configuration registers.
    assign is_pulsed   = (tone_idx != '0);
    assign tone_pulses = is_pulsed ? pulses_reg : '0;
    assign tone_trains = is_pulsed ? train_reps_reg : '0;
    assign on_cmp      = is_pulsed ? CMP_W'(pulse_on_reg)  : '0;
    assign off_cmp     = is_pulsed ? CMP_W'(pulse_off_reg) : '0;
    assign gap_cmp     = is_pulsed ? CMP_W'(train_gap_reg) : '0;
    assign pulse_inc   = pulse_count_reg + COUNT_W'(1);

    // The phase timer saturates rather than wrapping.
    assign timer_tick = (phase_timer_reg == '1) ? phase_timer_reg
                                                : phase_timer_reg + TIMER_WIDTH'(1);
    assign timer_cmp  = CMP_W'(timer_tick);

    always_comb begin
        request_mask_next = request_mask_reg;
        was_active_next   = was_active_reg;
        phase_next        = phase_reg;
        last_tone_next    = last_tone_reg;
        pulse_count_next  = pulse_count_reg;
        train_count_next  = train_count_reg;
        phase_timer_next  = phase_timer_reg;
        drive_next        = drive_reg;
        run_start         = 1'b0;

        if (exec) begin
            if (in_op_reg == OP_REQUEST) begin
                request_mask_next = (request_mask_reg | in_set_reg) & ~in_clr_reg;
            end else begin
                phase_timer_next = timer_tick;
                if (request_mask_reg != '0) begin
                    was_active_next = 1'b1;
                    // A new winner restarts its pattern from the start phase.
                    if (tone_idx != last_tone_reg) begin
                        drive_next       = 1'b0;
                        pulse_count_next = '0;
                        train_count_next = '0;
                        phase_next       = PH_START;
                        last_tone_next   = tone_idx;
                    end
                    case (phase_next)
                        PH_START: begin
                            run_start = 1'b1;
                        end
                        PH_STOP: begin
                            if (timer_cmp >= on_cmp) begin
                                phase_timer_next = '0;
                                drive_next       = 1'b0;
                                phase_next       = PH_NEXT;
                            end
                        end
                        PH_NEXT: begin
                            if (timer_cmp >= off_cmp) begin
                                pulse_count_next = pulse_inc;
                                if (tone_pulses > pulse_inc) begin
                                    phase_next = PH_START;
                                    run_start  = 1'b1;
                                end else begin
                                    train_count_next = train_count_reg + COUNT_W'(1);
                                    phase_next       = PH_CHECK;
                                end
                            end
                        end
                        PH_CHECK: begin
                            if (tone_trains > train_count_reg || tone_trains == '0) begin
                                if (timer_cmp >= gap_cmp) begin
                                    pulse_count_next = '0;
                                    phase_next       = PH_START;
                                    run_start        = 1'b1;
                                end
                            end else begin
                                // The tone is finished: the step ends here.
                                request_mask_next = request_mask_reg & keep_mask;
                                last_tone_next    = TONE_NONE;
                                pulse_count_next  = '0;
                                train_count_next  = '0;
                                phase_next        = PH_START;
                            end
                        end
                        PH_DONE: begin
                            if (!is_pulsed && in_avail_reg) begin
                                drive_next = 1'b1;
                            end
                        end
                        default: begin
                            phase_next = PH_START;
                            run_start  = 1'b1;
                        end
                    endcase
                    // Entering the start phase runs it within the same tick.
                    if (run_start) begin
                        if (in_avail_reg) begin
                            drive_next = 1'b1;
                        end
                        if (tone_pulses == '0) begin
                            phase_next = PH_DONE;
                        end else begin
                            phase_timer_next = '0;
                            phase_next       = PH_STOP;
                        end
                    end
                end
                // The buzzer goes quiet on the first tick that ends with no request pending.
                if (request_mask_next == '0 && was_active_next) begin
                    was_active_next = 1'b0;
                    drive_next      = 1'b0;
                end
            end
        end
    end

    // With no tone selected the sequencer rests in the start phase, counters clear.
    a_idle_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_tone_reg == TONE_NONE) |->
            (phase_reg == PH_START && pulse_count_reg == '0 && train_count_reg == '0))
        else $error("sequencer left idle state with no tone selected");

    // The buzzer can only be on while a tone has been active.
    a_drive_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        drive_reg |-> was_active_reg)
        else $error("buzzer driven without active tone");

    // A stalled result with a full input register must block new transfers.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg) |-> !s_ready)
        else $error("input accepted while pipeline full");

    // A tick executed with no request leaves the buzzer off.
    a_empty_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && in_op_reg == OP_TICK && request_mask_reg == '0) |=> !drive_reg)
        else $error("buzzer on after tick with empty request mask");

endmodule
